FILE: src/nps_pkg.sv
package nps_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int START_BITS         = 32;
    localparam int PRIME_BITS         = 32;

    localparam int SMALLEST_PRIME     = 2;
    localparam int FIRST_DIVISOR      = 3;
    localparam int FIRST_COMPOSITE    = 4;
    localparam int DIVISOR_STEP       = 2;

endpackage

FILE: src/next_prime_search.sv
// Smallest prime at or above the start value, by trial division.
// Each candidate is tested in turn: the small cases are settled directly, else each odd
// divisor tried is checked with the radix-2 restoring divider.
// Throughput: one word at a time; the next word is taken once the result is loaded into
// the output register, even while that result still waits there to be taken.
// Reset (rst_n low, asynchronous) returns to idle and drops any pending result.
module next_prime_search
    import nps_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [START_BITS-1:0] s_tdata,   // [31:0] start_value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PRIME_BITS-1:0] m_tdata,   // [31:0] prime_value
    output logic                  m_tuser    // [0] no_prime_fits
);

    localparam int W     = VALUE_BITS;
    localparam int CNT_W = $clog2(W);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TEST  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_ADV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [W-1:0]          cand_reg,  cand_next;
    logic [W-1:0]          dvd_reg,   dvd_next;
    logic [W-1:0]          rem_reg,   rem_next;
    logic [W-1:0]          div_reg,   div_next;
    logic [CNT_W-1:0]      cnt_reg,   cnt_next;
    logic                  fit_reg,   fit_next;
    logic                  ovalid_reg, ovalid_next;
    logic [PRIME_BITS-1:0] odata_reg, odata_next;
    logic                  ouser_reg, ouser_next;

    logic [W+START_BITS-1:0] in_wide;
    logic [W+PRIME_BITS-1:0] cand_wide;
    logic [W:0]              trial;
    logic [W:0]              diff;
    logic                    qbit;
    logic                    out_free;

    assign in_wide   = {{W{1'b0}}, s_tdata};
    assign cand_wide = {{PRIME_BITS{1'b0}}, cand_reg};
    assign trial     = {rem_reg, dvd_reg[W-1]};
    assign diff      = trial - {1'b0, div_reg};
    assign qbit      = ~diff[W];
    assign out_free  = ~ovalid_reg | m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;

    always_comb
    begin
        state_next  = state_reg;
        cand_next   = cand_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        cnt_next    = cnt_reg;
        fit_next    = fit_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        ouser_next  = ouser_reg;

        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cand_next  = in_wide[W-1:0];
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (cand_reg < W'(SMALLEST_PRIME))
                begin
                    state_next = ST_ADV;
                end
                else if (cand_reg < W'(FIRST_COMPOSITE))
                begin
                    fit_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (!cand_reg[0])
                begin
                    state_next = ST_ADV;
                end
                else
                begin
                    div_next   = W'(FIRST_DIVISOR);
                    dvd_next   = cand_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // shift one quotient bit in per cycle
                rem_next = qbit ? diff[W-1:0] : trial[W-1:0];
                dvd_next = {dvd_reg[W-2:0], qbit};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(W - 1))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (div_reg > dvd_reg)
                begin
                    fit_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (rem_reg == '0)
                begin
                    state_next = ST_ADV;
                end
                else
                begin
                    div_next   = div_reg + W'(DIVISOR_STEP);
                    dvd_next   = cand_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_ADV:
            begin
                if (cand_reg == '1)
                begin
                    fit_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cand_next  = cand_reg + W'(1);
                    state_next = ST_TEST;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = fit_reg ? cand_wide[PRIME_BITS-1:0] : '0;
                    ouser_next  = ~fit_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg  <= cand_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        cnt_reg   <= cnt_next;
        fit_reg   <= fit_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
    end

endmodule

FILE: src/nps_check.sv
module nps_check
    import nps_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [START_BITS-1:0] s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [PRIME_BITS-1:0] m_tdata,
    input logic                  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again before search ended");

    a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("no-fit word carries a nonzero value");

    a_prime_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata != '0)
        else $error("found prime reads as zero");

    a_prime_odd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser && m_tdata != PRIME_BITS'(SMALLEST_PRIME) |-> m_tdata[0])
        else $error("even prime other than two");

endmodule

bind next_prime_search nps_check u_nps_check (.*);

FILE: verif/tb_next_prime_search.sv
`timescale 1ns / 1ps

module tb_next_prime_search;
    import nps_pkg::*;

    localparam int     VALUE_BITS      = VALUE_BITS_DEFAULT;
    localparam int     CLK_HALF        = 4;
    localparam int     RESET_CYCLES    = 11;
    localparam int     RANDOM_STARTS   = 71;
    localparam int     BURST_STARTS    = 10;
    localparam int     HOLD_OFF_CYCLES = 3000;
    localparam int     DRAIN_CYCLES    = 200;
    localparam longint CYCLE_LIMIT     = 6_000_000;

    localparam logic [START_BITS-1:0] DIRECTED_STARTS [19] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd24, 32'd25, 32'd49,
        32'd90, 32'd114, 32'd65521, 32'd65522, 32'd1000000,
        32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFC, 32'd7
    };

    typedef struct packed {
        logic [PRIME_BITS-1:0] prime_value;
        logic                  no_prime_fits;
    } prime_answer_t;

    class prime_scoreboard;
        prime_answer_t expected_q[$];
        int            errors;
        int            starts_seen;
        int            answers_seen;
        int            no_fit_seen;

        function new();
            errors       = 0;
            starts_seen  = 0;
            answers_seen = 0;
            no_fit_seen  = 0;
        endfunction

        function bit is_prime(longint unsigned n);
            longint unsigned d;
            if (n < SMALLEST_PRIME)
                return 1'b0;
            if (n < FIRST_COMPOSITE)
                return 1'b1;
            if (n[0] == 1'b0)
                return 1'b0;
            for (d = FIRST_DIVISOR; d <= n / d; d += DIVISOR_STEP)
            begin
                if (n % d == 0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function prime_answer_t search_from(logic [START_BITS-1:0] start);
            longint unsigned top;
            longint unsigned cand;
            prime_answer_t   answer;
            top                  = {64{1'b1}} >> (64 - VALUE_BITS);
            cand                 = 64'(start) & top;
            answer.prime_value   = '0;
            answer.no_prime_fits = 1'b1;
            forever
            begin
                if (is_prime(cand))
                begin
                    answer.prime_value   = cand[PRIME_BITS-1:0];
                    answer.no_prime_fits = 1'b0;
                    break;
                end
                if (cand >= top)
                    break;
                cand++;
            end
            return answer;
        endfunction

        function void note_start(logic [START_BITS-1:0] start);
            expected_q.push_back(search_from(start));
            starts_seen++;
        endfunction

        function void check_result(logic [PRIME_BITS-1:0] prime_value, logic no_prime_fits);
            prime_answer_t want;
            answers_seen++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected word: prime_value=%0d no_prime_fits=%0b",
                       prime_value, no_prime_fits);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (prime_value !== want.prime_value)
            begin
                $error("prime_value: expected %0d, got %0d", want.prime_value, prime_value);
                errors++;
            end
            if (no_prime_fits !== want.no_prime_fits)
            begin
                $error("no_prime_fits: expected %0b, got %0b",
                       want.no_prime_fits, no_prime_fits);
                errors++;
            end
            if (want.no_prime_fits)
                no_fit_seen++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [START_BITS-1:0] s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [PRIME_BITS-1:0] m_tdata;
    logic                  m_tuser;

    prime_scoreboard sb;
    bit              no_idle      = 1'b0;
    bit              hold_request = 1'b0;
    int              holds_done   = 0;
    longint          cycle_count  = 0;

    next_prime_search #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF clk = ~clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [START_BITS-1:0] random_start();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return $urandom_range(0, 4095);
        if (pick < 85)
            return $urandom & 32'h0000_FFFF;
        if (pick < 97)
            return $urandom & 32'h000F_FFFF;
        return 32'hFFFF_FFFE | ($urandom & 32'h1);
    endfunction

    task automatic send_start(input logic [START_BITS-1:0] start);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= start;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_start(start);
        if (!no_idle && $urandom_range(0, 2) == 0)
        begin
            gap = pick_gap();
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
                holds_done++;
            end
            if (stall_left == 0 && !no_idle && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("timeout after %0d cycles with %0d answers outstanding",
               cycle_count, sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_STARTS[i])
            send_start(DIRECTED_STARTS[i]);

        for (int i = 0; i < RANDOM_STARTS; i++)
        begin
            if (i == 30)
                no_idle = 1'b1;
            if (i == 45)
                no_idle = 1'b0;
            if (i == 60)
            begin
                // hold the output so the block backs up its input
                no_idle      = 1'b1;
                hold_request = 1'b1;
                for (int j = 0; j < BURST_STARTS; j++)
                    send_start($urandom_range(0, 63));
                no_idle = 1'b0;
            end
            send_start(random_start());
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Searched %0d start values and checked %0d answers, %0d of them past the top",
                 sb.starts_seen, sb.answers_seen, sb.no_fit_seen);
        $display("Output held off %0d time(s) with the input backed up; %0d cycles run",
                 holds_done, cycle_count);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
